// ===== hw/rtl/scbe_pkg.sv =====
`timescale 1ns / 1ps

package scbe_pkg;

  // Command codes.
  localparam logic [2:0] F_READ     = 3'd0;
  localparam logic [2:0] F_ADD      = 3'd1;
  localparam logic [2:0] F_SET      = 3'd2;
  localparam logic [2:0] F_TEST     = 3'd3;
  localparam logic [2:0] F_REGISTER = 3'd4;
  localparam logic [2:0] F_CHECK    = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Shared arithmetic unit operations.
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  counter_id;
    logic [31:0] operand_value;
    logic [31:0] event_key;
  } request_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        satisfied;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  counter_id;
    logic [31:0] threshold;
  } ev_entry_t;

  typedef struct packed {
    logic zero;
    logic reached;
  } alu_flags_t;

endpackage

// ===== hw/rtl/scbe_ram.sv =====
`timescale 1ns / 1ps

module scbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/scbe_alu.sv =====
`timescale 1ns / 1ps

module scbe_alu
  import scbe_pkg::*;
(
  input  logic        op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y,
  output alu_flags_t  flags
);

  // One 32-bit adder serves addition, the threshold test and key comparison.
  always_comb begin
    y = a + (op == ALU_SUB ? ~b : b) + {31'd0, op == ALU_SUB};
    flags.zero    = (y == 32'd0);
    flags.reached = ~y[31];
  end

endmodule

// ===== hw/rtl/sync_counter_bank_with_events_top.sv =====
// Read, add, set and test pass through a counter read and an execute state
// before the done strobe; a bad counter id, an add of zero or an unused code
// is answered straight from idle. Register and check event walk the event
// table, one slot per cycle, and check event then tests the hit's counter.
// A new command may start in the cycle its predecessor's result is shown.
// Synchronous reset zeroes all counters and empties the event table at once.
`timescale 1ns / 1ps

module sync_counter_bank_with_events_top
  import scbe_pkg::*;
#(
  parameter int COUNTER_COUNT = 192,
  parameter int EVENT_SLOTS   = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int CNT_W  = (COUNTER_COUNT > 1) ? $clog2(COUNTER_COUNT) : 1;
  localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int SCAN_W = $clog2(EVENT_SLOTS + 1);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(EVENT_SLOTS);
  localparam logic [8:0] ID_LIMIT = 9'(COUNTER_COUNT);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CRD     = 3'd1;
  localparam logic [2:0] S_CEX     = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_RESOLVE = 3'd4;
  localparam logic [2:0] S_EVRD    = 3'd5;
  localparam logic [2:0] S_EVEX    = 3'd6;

  logic [2:0]               state;
  request_t                 cmd;
  logic [COUNTER_COUNT-1:0] cval;
  logic [EVENT_SLOTS-1:0]   ev_valid;
  logic [CNT_W-1:0]         caddr;
  logic [SCAN_W-1:0]        scan_idx;
  logic [SLOT_W-1:0]        cmp_idx;
  logic                     cmp_live;
  logic                     found;
  logic [SLOT_W-1:0]        hit_idx;
  ev_entry_t                hit_entry;
  logic                     free_found;
  logic [SLOT_W-1:0]        free_idx;

  logic [CNT_W-1:0]  cnt_raddr;
  logic [31:0]       cnt_rdata;
  logic              cnt_we;
  logic [31:0]       cnt_wdata;
  logic [31:0]       cval_data;
  ev_entry_t         ev_rdata;
  logic              ev_we;
  logic [SLOT_W-1:0] ev_waddr;
  ev_entry_t         ev_wdata;
  logic [SLOT_W-1:0] scan_slot;
  logic              scan_live;
  logic              alu_op;
  logic [31:0]       alu_a;
  logic [31:0]       alu_b;
  logic [31:0]       alu_y;
  alu_flags_t        alu_flags;
  logic              req_id_ok;
  logic              hit_id_ok;

  assign busy      = (state != S_IDLE);
  assign req_id_ok = ({1'b0, request.counter_id} < ID_LIMIT);
  assign hit_id_ok = ({1'b0, hit_entry.counter_id} < ID_LIMIT);
  assign scan_slot = scan_idx[SLOT_W-1:0];
  assign scan_live = (scan_idx < SCAN_END);

  // A counter that was never written since reset reads as zero.
  assign cval_data = cval[caddr] ? cnt_rdata : 32'd0;

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = cval_data;
    alu_b  = cmd.operand_value;
    unique case (state)
      S_CEX: begin
        if (cmd.func == F_ADD) begin
          alu_op = ALU_ADD;
        end
      end
      S_SCAN: begin
        alu_a = ev_rdata.key;
        alu_b = cmd.event_key;
      end
      S_EVEX: begin
        alu_b = hit_entry.threshold;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_raddr = (state == S_EVRD) ? hit_entry.counter_id[CNT_W-1:0]
                                  : cmd.counter_id[CNT_W-1:0];
    cnt_we    = (state == S_CEX) && (cmd.func == F_ADD || cmd.func == F_SET);
    cnt_wdata = (cmd.func == F_ADD) ? alu_y : cmd.operand_value;

    ev_we               = (state == S_RESOLVE) && (cmd.func == F_REGISTER)
                          && (found || free_found);
    ev_waddr            = found ? hit_idx : free_idx;
    ev_wdata.key        = cmd.event_key;
    ev_wdata.counter_id = cmd.counter_id;
    ev_wdata.threshold  = cmd.operand_value;
  end

  scbe_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .y     (alu_y),
    .flags (alu_flags)
  );

  scbe_ram #(
    .WIDTH (32),
    .DEPTH (COUNTER_COUNT)
  ) u_counter_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (caddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  scbe_ram #(
    .WIDTH ($bits(ev_entry_t)),
    .DEPTH (EVENT_SLOTS)
  ) u_event_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .raddr (scan_slot),
    .rdata (ev_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      cval     <= '0;
      ev_valid <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd               <= request;
            scan_idx          <= '0;
            cmp_live          <= 1'b0;
            found             <= 1'b0;
            free_found        <= 1'b0;
            result.result_value <= 32'd0;
            result.satisfied  <= 1'b0;
            result.status     <= ST_OK;
            if (request.func == F_REGISTER || request.func == F_CHECK) begin
              state <= S_SCAN;
            end else if (request.func <= F_TEST && req_id_ok &&
                         !(request.func == F_ADD && request.operand_value == 32'd0)) begin
              state <= S_CRD;
            end else begin
              result.status <= ST_BAD;
              done          <= 1'b1;
            end
          end
        end
        S_CRD: begin
          caddr <= cnt_raddr;
          state <= S_CEX;
        end
        S_CEX: begin
          unique case (cmd.func)
            F_READ: result.result_value <= cval_data;
            F_ADD: begin
              result.result_value <= alu_y;
              cval[caddr]         <= 1'b1;
            end
            F_SET: cval[caddr] <= 1'b1;
            default: result.satisfied <= alu_flags.reached;
          endcase
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          // The table read is registered: the entry compared now belongs to
          // the slot addressed in the previous cycle.
          if (cmp_live && ev_valid[cmp_idx] && alu_flags.zero && !found) begin
            found     <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_entry <= ev_rdata;
          end
          if (scan_live && !ev_valid[scan_slot] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= scan_slot;
          end
          cmp_idx  <= scan_slot;
          cmp_live <= scan_live;
          if (scan_live) begin
            scan_idx <= scan_idx + 1'b1;
          end else begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (cmd.func == F_REGISTER) begin
            if (found || free_found) begin
              ev_valid[ev_waddr] <= 1'b1;
            end else begin
              result.status <= ST_FULL;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (!found) begin
            result.status <= ST_NOTFOUND;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else if (!hit_id_ok) begin
            // An event tied to a non-existent counter never fires.
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_EVRD;
          end
        end
        S_EVRD: begin
          caddr <= cnt_raddr;
          state <= S_EVEX;
        end
        S_EVEX: begin
          if (alu_flags.reached) begin
            result.satisfied  <= 1'b1;
            ev_valid[hit_idx] <= 1'b0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only follows a transaction that was accepted or in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy || start))
    else $error("Result strobe without a transaction in progress.");

  // An accepted command either makes the block busy or is answered at once.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("Accepted command did not start.");

  // Only event registration can report a full table.
  assert property (@(posedge clk) disable iff (rst)
      (done && result.status == ST_FULL) |-> (cmd.func == F_REGISTER))
    else $error("Table full reported for a command other than register.");

  // A satisfied result never carries an error status.
  assert property (@(posedge clk) disable iff (rst)
      (done && result.satisfied) |-> (result.status == ST_OK))
    else $error("Satisfied flag set alongside an error status.");

  // The free slot recorded during the walk stays free until the walk ends.
  assert property (@(posedge clk) disable iff (rst)
      (state == S_SCAN && free_found) |-> !ev_valid[free_idx])
    else $error("Recorded free slot is occupied.");

endmodule
